/* sv/cfq_pkg.sv */
// ============================================================================
// cfq_pkg - shared types and constants of the CSV field quoting encoder
// Holds byte codes, register indexes and the status bundle that the field
// buffer hands to the emit sequencer.
// ============================================================================
`timescale 1ns / 1ps

package cfq_pkg;

  // Default field buffer depth
  localparam int unsigned FieldMaxDef = 30;

  // Fixed byte codes
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // Register reset values
  localparam logic [7:0] QuoteCharRst = 8'd34;
  localparam logic [7:0] DelimCharRst = 8'd44;

  // Register indexes (word address)
  localparam logic [1:0] RegQuoteChar = 2'd0;
  localparam logic [1:0] RegDelimChar = 2'd1;
  localparam logic [1:0] RegQuoteAll  = 2'd2;

  // Buffer status: flags that travel with the stored field
  typedef struct packed {
    logic needs_quoting;
    logic overflowed;
    logic empty;
  } buf_status_t;

endpackage

/* sv/cfq_buffer.sv */
// ============================================================================
// cfq_buffer - field byte store with length count and quoting check
// Keeps up to FIELD_MAX bytes of the open field, compares each kept byte
// against quote, delimiter, CR and LF, and flags bytes dropped on overflow.
// ============================================================================
`timescale 1ns / 1ps

module cfq_buffer
  import cfq_pkg::*;
#(
  parameter int unsigned FIELD_MAX = FieldMaxDef,
  localparam int unsigned LenW = $clog2(FIELD_MAX + 1),
  localparam int unsigned IdxW = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [7:0]      wr_byte_i,
  input  logic            clr_i,
  input  logic [7:0]      quote_char_i,
  input  logic [7:0]      delim_char_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [7:0]      rd_byte_o,
  output logic [LenW-1:0] len_o,
  output buf_status_t     status_o
);

  logic [7:0]      store_q [FIELD_MAX];
  logic [LenW-1:0] len_q, len_d;
  logic            nq_q, nq_d;
  logic            ovf_q, ovf_d;
  logic            room;
  logic            special;

  assign room    = (len_q < LenW'(FIELD_MAX));
  assign special = (wr_byte_i == quote_char_i) || (wr_byte_i == delim_char_i) ||
                   (wr_byte_i == ChCr) || (wr_byte_i == ChLf);

  // Next length and flags: clear when the field is finished, else take a byte
  always_comb begin
    len_d = len_q;
    nq_d  = nq_q;
    ovf_d = ovf_q;
    if (clr_i) begin
      len_d = '0;
      nq_d  = 1'b0;
      ovf_d = 1'b0;
    end else if (wr_en_i) begin
      if (room) begin
        len_d = len_q + LenW'(1);
        nq_d  = nq_q | special;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      nq_q  <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      nq_q  <= nq_d;
      ovf_q <= ovf_d;
    end
  end

  // Store the byte at the fill position
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clr_i && room) begin
      store_q[len_q[IdxW-1:0]] <= wr_byte_i;
    end
  end

  assign rd_byte_o              = store_q[rd_idx_i];
  assign len_o                  = len_q;
  assign status_o.needs_quoting = nq_q;
  assign status_o.overflowed    = ovf_q;
  assign status_o.empty         = (len_q == '0);

endmodule

/* sv/cfq_emitter.sv */
// ============================================================================
// cfq_emitter - emit sequencer with output register
// Walks the stored field through a single quote compare, one byte a cycle
// while output is free; adds enclosing and doubled quotes, separator bytes.
// ============================================================================
`timescale 1ns / 1ps

module cfq_emitter
  import cfq_pkg::*;
#(
  parameter int unsigned FIELD_MAX = FieldMaxDef,
  localparam int unsigned LenW = $clog2(FIELD_MAX + 1),
  localparam int unsigned IdxW = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            eor_i,
  input  logic            eot_i,
  output logic            idle_o,
  input  logic [7:0]      quote_char_i,
  input  logic [7:0]      delim_char_i,
  input  logic            quote_all_i,
  input  buf_status_t     status_i,
  input  logic [LenW-1:0] len_i,
  input  logic [7:0]      rd_byte_i,
  output logic [IdxW-1:0] rd_idx_o,
  output logic            clr_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            out_trunc_o
);

  typedef enum logic [2:0] {
    StIdle, StStart, StOpen, StBody, StClose, StSep, StLf
  } state_e;

  state_e          state_q, state_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic            dbl_q, dbl_d;
  logic            quoted_q, quoted_d;
  logic            eor_q, eor_d;
  logic            eot_q, eot_d;
  logic            ov_q, ov_d;
  logic [7:0]      ob_q, ob_d;
  logic            ol_q, ol_d;
  logic            ot_q, ot_d;
  logic            slot_free;
  logic            emit;
  logic [7:0]      emit_byte;
  state_e          sep_state;
  state_e          after_body;
  state_e          first_state;
  logic            is_quote;

  assign slot_free = !ov_q || out_ready_i;
  assign is_quote  = (rd_byte_i == quote_char_i);

  // Routing into the field and after the field body
  always_comb begin
    if (!eor_q) begin
      sep_state = StSep;
    end else if (!eot_q) begin
      sep_state = StSep;
    end else begin
      sep_state = StIdle;
    end
    after_body = quoted_q ? StClose : sep_state;
    if (quote_all_i || status_i.needs_quoting) begin
      first_state = StOpen;
    end else if (!status_i.empty) begin
      first_state = StBody;
    end else begin
      first_state = sep_state;
    end
  end

  // Sequencer: pick the next byte and the next step
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    dbl_d     = dbl_q;
    quoted_d  = quoted_q;
    eor_d     = eor_q;
    eot_d     = eot_q;
    emit      = 1'b0;
    emit_byte = quote_char_i;
    clr_o     = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          eor_d   = eor_i;
          eot_d   = eot_i & eor_i;
          state_d = StStart;
        end
      end
      StStart: begin
        quoted_d = quote_all_i | status_i.needs_quoting;
        idx_d    = '0;
        dbl_d    = 1'b0;
        state_d  = first_state;
        if (first_state == StIdle) begin
          clr_o = 1'b1;
        end
      end
      StOpen: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = status_i.empty ? StClose : StBody;
        end
      end
      StBody: begin
        if (slot_free) begin
          emit = 1'b1;
          if (quoted_q && is_quote && !dbl_q) begin
            dbl_d = 1'b1;
          end else begin
            emit_byte = rd_byte_i;
            dbl_d     = 1'b0;
            idx_d     = idx_q + LenW'(1);
            if (idx_d == len_i) begin
              state_d = after_body;
            end
          end
        end
      end
      StClose: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = sep_state;
        end
      end
      StSep: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = !eor_q ? delim_char_i : ChCr;
          state_d   = !eor_q ? StIdle : StLf;
        end
      end
      StLf: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = ChLf;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (emit && state_d == StIdle) begin
      clr_o = 1'b1;
    end
  end

  // Output register: load on emit, drop once taken
  always_comb begin
    ov_d = ov_q;
    ob_d = ob_q;
    ol_d = ol_q;
    ot_d = ot_q;
    if (emit) begin
      ov_d = 1'b1;
      ob_d = emit_byte;
      ol_d = (state_d == StIdle);
      ot_d = status_i.overflowed;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      dbl_q    <= 1'b0;
      quoted_q <= 1'b0;
      eor_q    <= 1'b0;
      eot_q    <= 1'b0;
      ov_q     <= 1'b0;
      ob_q     <= '0;
      ol_q     <= 1'b0;
      ot_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      dbl_q    <= dbl_d;
      quoted_q <= quoted_d;
      eor_q    <= eor_d;
      eot_q    <= eot_d;
      ov_q     <= ov_d;
      ob_q     <= ob_d;
      ol_q     <= ol_d;
      ot_q     <= ot_d;
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign rd_idx_o    = idx_q[IdxW-1:0];
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;
  assign out_trunc_o = ot_q;

endmodule

/* sv/csv_field_quoting_encoder.sv */
// Sequence: an item without field end is taken while idle; a field end is accepted,
//   then a decision step picks the first byte, then each byte is emitted in turn.
// Bytes per field: N raw, or N + quotes_in_field + 2 when quoted, plus separator if any.
// Throughput: one emitted byte per cycle while the output is taken; input is not ready during emission.
// Reset: rst_ni asynchronous active low; clears length, flags, sequencer and
//   output valid; registers return to quote 34, delimiter 44, no quote-all.
// ============================================================================
// csv_field_quoting_encoder - CSV field escaping encoder
// Buffers one field, then emits it raw or quoted with doubled inner quotes,
// followed by the delimiter or CR LF, or by nothing at table end.
// ============================================================================
`timescale 1ns / 1ps

module csv_field_quoting_encoder
  import cfq_pkg::*;
#(
  parameter int unsigned FIELD_MAX = FieldMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_field
  input  logic [2:0]  s_axis_tuser,   // [0] has_byte, [1] end_of_row, [2] end_of_table
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // last_of_burst
  output logic        m_axis_tuser    // [0] field_truncated
);

  localparam int unsigned LenW = $clog2(FIELD_MAX + 1);
  localparam int unsigned IdxW = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;

  logic [7:0]      quote_char_q;
  logic [7:0]      delim_char_q;
  logic            quote_all_q;
  logic            cfg_wr;
  logic            in_acc;
  logic            idle;
  logic            clr;
  logic [IdxW-1:0] rd_idx;
  logic [7:0]      rd_byte;
  logic [LenW-1:0] len;
  buf_status_t     status;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_char_q <= QuoteCharRst;
      delim_char_q <= DelimCharRst;
      quote_all_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegQuoteChar: quote_char_q <= pwdata[7:0];
        RegDelimChar: delim_char_q <= pwdata[7:0];
        RegQuoteAll:  quote_all_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegQuoteChar: prdata = {24'd0, quote_char_q};
      RegDelimChar: prdata = {24'd0, delim_char_q};
      RegQuoteAll:  prdata = {31'd0, quote_all_q};
      default:      prdata = '0;
    endcase
  end

  // Accept items only while the sequencer is idle
  assign s_axis_tready = idle;
  assign in_acc        = s_axis_tvalid && idle;

  cfq_buffer #(
    .FIELD_MAX(FIELD_MAX)
  ) u_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_acc && s_axis_tuser[0]),
    .wr_byte_i   (s_axis_tdata),
    .clr_i       (clr),
    .quote_char_i(quote_char_q),
    .delim_char_i(delim_char_q),
    .rd_idx_i    (rd_idx),
    .rd_byte_o   (rd_byte),
    .len_o       (len),
    .status_o    (status)
  );

  cfq_emitter #(
    .FIELD_MAX(FIELD_MAX)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc && s_axis_tlast),
    .eor_i       (s_axis_tuser[1]),
    .eot_i       (s_axis_tuser[2]),
    .idle_o      (idle),
    .quote_char_i(quote_char_q),
    .delim_char_i(delim_char_q),
    .quote_all_i (quote_all_q),
    .status_i    (status),
    .len_i       (len),
    .rd_byte_i   (rd_byte),
    .rd_idx_o    (rd_idx),
    .clr_o       (clr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_trunc_o (m_axis_tuser)
  );

endmodule

/* tb/tb_csv_field_quoting_encoder.sv */
// ============================================================================
// tb_csv_field_quoting_encoder - self-checking bench of the CSV field encoder
// Streams CSV field bytes with field, row and table marks into the encoder.
// Predicts the escaped byte stream in the bench and compares every output
// item field by field. Random stalls on both streams, APB register changes
// between phases.
// ============================================================================
`timescale 1ns / 1ps

module tb_csv_field_quoting_encoder;
  import cfq_pkg::*;

  localparam int unsigned FieldMax  = FieldMaxDef;
  localparam int unsigned IdlePct   = 34;
  localparam int unsigned StallLim  = 5000;
  localparam int unsigned SettleCyc = 8;

  // One input item and one output item
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eof;
    logic       eor;
    logic       eot;
  } csv_item_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
    logic       trunc;
  } csv_byte_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0; // end_of_field
  logic [2:0]  s_axis_tuser  = '0;   // [0] has_byte, [1] end_of_row, [2] end_of_table
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic        m_axis_tlast;         // last_of_burst
  logic        m_axis_tuser;         // [0] field_truncated

  csv_field_quoting_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Bench copy of the encoder state and registers
  logic [7:0] fld_buf [FieldMax];
  int unsigned fld_len   = 0;
  logic        fld_quote = 1'b0;
  logic        fld_ovf   = 1'b0;
  logic [7:0]  cfg_quote = QuoteCharRst;
  logic [7:0]  cfg_delim = DelimCharRst;
  logic        cfg_all   = 1'b0;

  csv_item_t   item_q [$];
  csv_byte_t   csv_text_q [$];
  csv_item_t   cur_item    = '0;
  logic        steady      = 1'b0;
  logic        input_hold  = 1'b0;
  int unsigned err_cnt     = 0;
  int unsigned staged      = 0;
  int unsigned items_in    = 0;
  int unsigned fields_done = 0;
  int unsigned trunc_done  = 0;
  int unsigned bytes_seen  = 0;
  int unsigned settings    = 1;
  int unsigned quiet_cyc   = 0;

  // Take one accepted item into the field and queue the text it emits
  function automatic void encode_field_item(input csv_item_t it);
    csv_byte_t burst [$];
    logic      quoted;
    if (it.has) begin
      if (fld_len < FieldMax) begin
        fld_buf[fld_len] = it.data;
        fld_len++;
        if (it.data == cfg_quote || it.data == cfg_delim ||
            it.data == ChCr || it.data == ChLf)
          fld_quote = 1'b1;
      end else begin
        fld_ovf = 1'b1;
      end
    end
    if (!it.eof) return;
    quoted = cfg_all | fld_quote;
    if (quoted) burst.push_back(csv_byte_t'{cfg_quote, 1'b0, fld_ovf});
    for (int unsigned i = 0; i < fld_len; i++) begin
      if (quoted && fld_buf[i] == cfg_quote)
        burst.push_back(csv_byte_t'{cfg_quote, 1'b0, fld_ovf});
      burst.push_back(csv_byte_t'{fld_buf[i], 1'b0, fld_ovf});
    end
    if (quoted) burst.push_back(csv_byte_t'{cfg_quote, 1'b0, fld_ovf});
    // Separator: delimiter inside a row, CR LF between rows, none at table end
    if (!it.eor) begin
      burst.push_back(csv_byte_t'{cfg_delim, 1'b0, fld_ovf});
    end else if (!it.eot) begin
      burst.push_back(csv_byte_t'{ChCr, 1'b0, fld_ovf});
      burst.push_back(csv_byte_t'{ChLf, 1'b0, fld_ovf});
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[k]) csv_text_q.push_back(burst[k]);
    fields_done++;
    if (fld_ovf) trunc_done++;
    fld_len   = 0;
    fld_quote = 1'b0;
    fld_ovf   = 1'b0;
  endfunction

  // Input driver: present queued items, hold each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_field_item(cur_item);
        items_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() > 0 && !input_hold &&
            (steady || $urandom_range(99) >= IdlePct)) begin
          cur_item      <= item_q[0];
          s_axis_tdata  <= item_q[0].data;
          s_axis_tlast  <= item_q[0].eof;
          s_axis_tuser  <= {item_q[0].eot, item_q[0].eor, item_q[0].has};
          s_axis_tvalid <= 1'b1;
          void'(item_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each emitted byte against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_seen++;
        if (csv_text_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected byte %02h last %0b trunc %0b", $time,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          if (m_axis_tdata !== csv_text_q[0].val) begin
            err_cnt++;
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     csv_text_q[0].val, m_axis_tdata);
          end
          if (m_axis_tlast !== csv_text_q[0].last) begin
            err_cnt++;
            $display("%0t: last_of_burst expected %0b actual %0b", $time,
                     csv_text_q[0].last, m_axis_tlast);
          end
          if (m_axis_tuser !== csv_text_q[0].trunc) begin
            err_cnt++;
            $display("%0t: field_truncated expected %0b actual %0b", $time,
                     csv_text_q[0].trunc, m_axis_tuser);
          end
          void'(csv_text_q.pop_front());
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // Watchdog: count cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || !rst_ni) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= StallLim) begin
      $display("%0t: no progress for %0d cycles, %0d bytes still expected",
               $time, quiet_cyc, csv_text_q.size());
      $display("csv_field_quoting_encoder test failed");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  task automatic add_item(input logic [7:0] data, input logic has, input logic eof,
                          input logic eor, input logic eot);
    item_q.push_back(csv_item_t'{data, has, eof, eor, eot});
    if (has || eof) staged++;
  endtask

  // Wait until the input is drained and every expected byte has come out
  task automatic wait_idle();
    @(negedge clk_i);
    while (item_q.size() != 0 || s_axis_tvalid || csv_text_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write all three registers; the block is idle when this runs
  task automatic set_format(input logic [7:0] q, input logic [7:0] d, input logic all);
    apb_write(RegQuoteChar, q);
    apb_write(RegDelimChar, d);
    apb_write(RegQuoteAll, {7'd0, all});
    cfg_quote = q;
    cfg_delim = d;
    cfg_all   = all;
    settings++;
    @(negedge clk_i);
  endtask

  // Pick a field byte, leaning toward the bytes that force quoting
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0:       return cfg_quote;
      1:       return cfg_delim;
      2:       return ChCr;
      3:       return ChLf;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One field of random content, closed with the given row and table marks
  task automatic add_field(input logic eor, input logic eot);
    int unsigned len;
    int unsigned roll;
    logic        bare_close;
    roll = $urandom_range(99);
    if (roll < 8)       len = 0;
    else if (roll < 86) len = $urandom_range(8, 1);
    else if (roll < 95) len = $urandom_range(29, 9);
    else                len = $urandom_range(34, 30);
    bare_close = (len == 0) || ($urandom_range(4) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      // drop in a stray mark item now and then
      if ($urandom_range(15) == 0)
        add_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      if (k == len - 1 && !bare_close)
        add_item(pick_byte(), 1'b1, 1'b1, eor, eot);
      else
        add_item(pick_byte(), 1'b1, 1'b0, 1'($urandom_range(3) == 0),
                 1'($urandom_range(3) == 0));
    end
    if (bare_close) add_item(8'($urandom_range(255)), 1'b0, 1'b1, eor, eot);
  endtask

  // Rows of 1 to 5 fields until about n more items are staged
  task automatic add_rows(input int unsigned n);
    int unsigned goal;
    int unsigned nfld;
    logic        tbl_end;
    goal = staged + n;
    while (staged < goal) begin
      nfld    = $urandom_range(5, 1);
      tbl_end = ($urandom_range(6) == 0);
      for (int unsigned f = 0; f < nfld; f++) begin
        if (f == nfld - 1)
          add_field(1'b1, tbl_end);
        else
          add_field(1'b0, 1'($urandom_range(3) == 0));
      end
    end
  endtask

  initial begin
    logic [7:0] rq;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty field, byte extremes, each quoting trigger, mark corners
    add_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
    add_item(QuoteCharRst, 1'b1, 1'b1, 1'b1, 1'b0);
    add_item(DelimCharRst, 1'b1, 1'b1, 1'b0, 1'b0);
    add_item(ChCr, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(ChLf, 1'b1, 1'b1, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    add_item(8'h61, 1'b1, 1'b0, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
    add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    add_item(8'h5A, 1'b0, 1'b0, 1'b0, 1'b0);
    add_rows(35);
    wait_idle();

    // Quote everything, other quote and delimiter bytes
    set_format(8'h27, 8'h09, 1'b1);
    add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    add_rows(35);
    // hold the sender once until the output side has caught up
    while (item_q.size() > 25) @(negedge clk_i);
    input_hold = 1'b1;
    while (s_axis_tvalid || csv_text_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
    input_hold = 1'b0;
    wait_idle();

    // Byte extremes as register values
    set_format(8'h00, 8'hFF, 1'b0);
    add_rows(30);
    wait_idle();
    set_format(8'hFF, 8'h00, 1'b1);
    add_rows(30);
    wait_idle();

    // Defaults again with no stalls on either side
    set_format(QuoteCharRst, DelimCharRst, 1'b0);
    steady = 1'b1;
    add_rows(25);
    wait_idle();
    steady = 1'b0;

    // Random format, quote and delimiter often the same byte
    rq = 8'($urandom_range(255));
    set_format(rq, ($urandom_range(1) == 1) ? rq : 8'($urandom_range(255)),
               1'($urandom_range(1)));
    add_rows(25);
    wait_idle();
    repeat (SettleCyc) @(posedge clk_i);

    $display("Encoded %0d input items into %0d fields (%0d truncated), %0d bytes checked",
             items_in, fields_done, trunc_done, bytes_seen);
    $display("Covered %0d register settings, quote-all on and off, with and without stalls",
             settings);
    if (err_cnt == 0 && csv_text_q.size() == 0) begin
      $display("csv_field_quoting_encoder test passed");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", err_cnt, csv_text_q.size());
      $display("csv_field_quoting_encoder test failed");
    end
    $finish;
  end

endmodule
